@@ hdl/sm3_hash_drbg_top_defines.svh @@
// assertion macros of the sm3 hash drbg, included by sm3d_ctrl
// expects clk and arst_n in the scope of each use
`ifndef SM3_HASH_DRBG_TOP_DEFINES_SVH
`define SM3_HASH_DRBG_TOP_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define SM3D_ASSERT(lbl, prop, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// antecedent now implies consequent in the next cycle
`define SM3D_ASSERT_NEXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/sm3d_pkg.sv @@
// shared constants, types and helpers of the sm3 hash drbg
// no dependencies
package sm3d_pkg;

	localparam int SEED_BYTES_MAX    = 256;
	localparam int REQUEST_BYTES_MAX = 512;
	localparam int FILL_W            = $clog2(SEED_BYTES_MAX + 1);
	localparam int SEED_AW           = $clog2(SEED_BYTES_MAX);
	localparam int MSG_LEN_MAX       = 33 + SEED_BYTES_MAX;
	localparam int POS_W             = $clog2(MSG_LEN_MAX + 73);
	localparam int LEN_W             = 10;

	localparam logic [31:0]      RESEED_LIMIT_RST = 32'd1024;
	localparam logic [LEN_W-1:0] REQ_MAX          = LEN_W'(REQUEST_BYTES_MAX);

	// input command codes
	localparam logic [1:0] CMD_SEED   = 2'd0;
	localparam logic [1:0] CMD_RESEED = 2'd1;
	localparam logic [1:0] CMD_GEN    = 2'd2;
	localparam logic [1:0] CMD_IGNORE = 2'd3;

	// result status codes
	localparam logic [1:0] STS_OK          = 2'd0;
	localparam logic [1:0] STS_NOT_INST    = 2'd1;
	localparam logic [1:0] STS_RESEED_REQ  = 2'd2;

	// hash message prefix bytes
	localparam logic [7:0] PFX_DERIVE = 8'h00;
	localparam logic [7:0] PFX_RESEED = 8'h01;
	localparam logic [7:0] PFX_GEN    = 8'h02;
	localparam logic [7:0] PFX_UPDATE = 8'h03;

	// sm3 constants
	localparam logic [31:0] SM3_IV [8] = '{
		32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
		32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
	};
	localparam logic [31:0] SM3_T_LO = 32'h79cc4519;
	localparam logic [31:0] SM3_T_HI = 32'h7a879d8a;

	function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
		return (x << n) | (x >> (6'd32 - {1'b0, n}));
	endfunction

	// controller to datapath
	typedef struct packed {
		logic       store_byte;
		logic       cap_len;
		logic       start;
		logic [7:0] prefix;
		logic       use_seed;
		logic       inc_v;
		logic       vsel_t;
		logic       v_load;
		logic       c_load;
		logic       cnt_set1;
		logic       inst_set;
		logic       fill_clr;
		logic       t_load_v;
		logic       t_inc;
		logic       v_add_h;
		logic       v_add_c;
		logic       v_add_n;
		logic       cnt_inc;
		logic       push_data;
		logic       push_resp;
		logic [1:0] rsp_status;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic hash_busy;
		logic hash_done;
		logic inst;
		logic reseed_req;
		logic out_free;
		logic len_zero;
		logic emit_last;
		logic emit_blk_end;
	} dp_sts_t;

endpackage

@@ hdl/sm3d_in_if.sv @@
// request channel of the sm3 hash drbg: valid/ready plus input fields
// no dependencies
interface sm3d_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [7:0] data_byte;
	logic       end_of_seed;
	logic [9:0] request_length;

	modport source(output valid, command, data_byte, end_of_seed, request_length, input ready);
	modport sink(input valid, command, data_byte, end_of_seed, request_length, output ready);
endinterface

@@ hdl/sm3d_out_if.sv @@
// result channel of the sm3 hash drbg: valid/ready plus result fields
// no dependencies
interface sm3d_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] data_word;
	logic [3:0]  byte_count;
	logic [1:0]  status;
	logic        last_word;

	modport source(output valid, data_word, byte_count, status, last_word, input ready);
	modport sink(input valid, data_word, byte_count, status, last_word, output ready);
endinterface

@@ hdl/sm3d_core.sv @@
// sm3 hash engine: builds the padded message byte by byte, one round per cycle
// depends on sm3d_pkg; seed bytes come from a registered memory read outside
module sm3d_core import sm3d_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [7:0]         prefix,
	input  logic               use_seed,
	input  logic               inc_v,
	input  logic [FILL_W-1:0]  nseed,
	input  logic [255:0]       vec,
	output logic [SEED_AW-1:0] mem_addr,
	input  logic [7:0]         mem_rdata,
	output logic               busy,
	output logic               done,
	output logic [255:0]       digest
);

	typedef enum logic [3:0] {
		C_IDLE  = 4'b0001,
		C_LOAD  = 4'b0010,
		C_ROUND = 4'b0100,
		C_DONE  = 4'b1000
	} core_state_t;

	core_state_t      state_q;
	logic [POS_W-1:0] pos_q;
	logic [6:0]       ld_q;
	logic [5:0]       rnd_q;
	logic             vld_s1;
	logic             mem_s1;
	logic [7:0]       val_s1;

	logic [31:0] st_q [8];
	logic [31:0] wk_q [8];
	logic [31:0] w_q  [16];

	// message layout
	logic [POS_W-1:0] seed_n, msg_len, total, pm1;
	logic [POS_W+2:0] bitlen, len_sh;
	logic [4:0]       vidx;
	logic [2:0]       kidx;
	logic [255:0]     vec_sh;
	logic             from_mem;
	logic [7:0]       bval;
	logic             issue;
	logic [7:0]       byte_in;

	assign seed_n  = use_seed ? POS_W'(nseed) : '0;
	assign msg_len = POS_W'(1) + seed_n + (inc_v ? POS_W'(32) : '0);
	assign total   = (((msg_len + POS_W'(8)) >> 6) + POS_W'(1)) << 6;
	assign bitlen  = {msg_len, 3'b000};
	assign pm1     = pos_q - POS_W'(1);
	assign vidx    = 5'(pm1 - seed_n);
	assign kidx    = 3'(total - POS_W'(1) - pos_q);
	assign vec_sh  = vec >> {5'd31 - vidx, 3'b000};
	assign len_sh  = bitlen >> {kidx, 3'b000};
	assign mem_addr = pm1[SEED_AW-1:0];

	// byte at the current message position
	always_comb begin
		from_mem = 1'b0;
		bval     = 8'h00;
		if (pos_q < msg_len) begin
			if (pos_q == '0) begin
				bval = prefix;
			end else if (pm1 < seed_n) begin
				from_mem = 1'b1;
			end else begin
				bval = vec_sh[7:0];
			end
		end else if (pos_q == msg_len) begin
			bval = 8'h80;
		end else if (pos_q >= total - POS_W'(8)) begin
			bval = len_sh[7:0];
		end
	end

	assign issue   = !ld_q[6];
	assign byte_in = mem_s1 ? mem_rdata : val_s1;

	// round function
	logic [31:0] ra, rb, rc, rd, re, rf, rg, rh;
	logic [31:0] tj, a12, ss1, ss2, ff, gg, tt1, tt2, xw, wn;
	logic        early;
	logic [31:0] nwk [8];

	always_comb begin
		ra = wk_q[0]; rb = wk_q[1]; rc = wk_q[2]; rd = wk_q[3];
		re = wk_q[4]; rf = wk_q[5]; rg = wk_q[6]; rh = wk_q[7];
		early = (rnd_q < 6'd16);
		tj  = early ? SM3_T_LO : SM3_T_HI;
		a12 = rotl(ra, 5'd12);
		ss1 = rotl(a12 + re + rotl(tj, rnd_q[4:0]), 5'd7);
		ss2 = ss1 ^ a12;
		ff  = early ? (ra ^ rb ^ rc) : ((ra & rb) | (ra & rc) | (rb & rc));
		gg  = early ? (re ^ rf ^ rg) : ((re & rf) | (~re & rg));
		tt1 = ff + rd + ss2 + (w_q[0] ^ w_q[4]);
		tt2 = gg + rh + ss1 + w_q[0];
		nwk[0] = tt1;
		nwk[1] = ra;
		nwk[2] = rotl(rb, 5'd9);
		nwk[3] = rc;
		nwk[4] = tt2 ^ rotl(tt2, 5'd9) ^ rotl(tt2, 5'd17);
		nwk[5] = re;
		nwk[6] = rotl(rf, 5'd19);
		nwk[7] = rg;
		// message expansion for the word sixteen ahead
		xw = w_q[0] ^ w_q[7] ^ rotl(w_q[13], 5'd15);
		wn = xw ^ rotl(xw, 5'd15) ^ rotl(xw, 5'd23) ^ rotl(w_q[3], 5'd7) ^ w_q[10];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			pos_q   <= '0;
			ld_q    <= '0;
			rnd_q   <= '0;
			vld_s1  <= 1'b0;
		end else begin
			unique case (state_q) inside
				C_IDLE, C_DONE: begin
					if (start) begin
						pos_q   <= '0;
						ld_q    <= '0;
						vld_s1  <= 1'b0;
						state_q <= C_LOAD;
					end else begin
						state_q <= C_IDLE;
					end
				end
				C_LOAD: begin
					vld_s1 <= issue;
					if (issue) begin
						pos_q <= pos_q + POS_W'(1);
						ld_q  <= ld_q + 7'd1;
					end else if (vld_s1) begin
						rnd_q   <= '0;
						state_q <= C_ROUND;
					end
				end
				C_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						ld_q    <= '0;
						vld_s1  <= 1'b0;
						state_q <= (pos_q == total) ? C_DONE : C_LOAD;
					end
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	// byte stage, window, working and chaining registers
	always_ff @(posedge clk) begin
		if (state_q == C_LOAD && issue) begin
			mem_s1 <= from_mem;
			val_s1 <= bval;
		end
		if ((state_q == C_IDLE || state_q == C_DONE) && start) begin
			for (int i = 0; i < 8; i++) st_q[i] <= SM3_IV[i];
		end
		if (state_q == C_LOAD && vld_s1) begin
			for (int i = 0; i < 15; i++) w_q[i] <= {w_q[i][23:0], w_q[i+1][31:24]};
			w_q[15] <= {w_q[15][23:0], byte_in};
		end
		if (state_q == C_LOAD && !issue && vld_s1) begin
			for (int i = 0; i < 8; i++) wk_q[i] <= st_q[i];
		end
		if (state_q == C_ROUND) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wn;
			for (int i = 0; i < 8; i++) wk_q[i] <= nwk[i];
			if (rnd_q == 6'd63) begin
				for (int i = 0; i < 8; i++) st_q[i] <= st_q[i] ^ nwk[i];
			end
		end
	end

	assign busy   = (state_q == C_LOAD) || (state_q == C_ROUND);
	assign done   = (state_q == C_DONE);
	assign digest = {st_q[0], st_q[1], st_q[2], st_q[3], st_q[4], st_q[5], st_q[6], st_q[7]};

endmodule

@@ hdl/sm3d_dpath.sv @@
// drbg datapath: seed memory, V, C, counter, limit, word output register
// depends on sm3d_pkg and sm3d_core
module sm3d_dpath import sm3d_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  dp_cmd_t          cmd,
	output dp_sts_t          sts,
	input  logic [7:0]       data_byte,
	input  logic [LEN_W-1:0] request_length,
	input  logic             cfg_we,
	input  logic [31:0]      cfg_wdata,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [63:0]      data_word,
	output logic [3:0]       byte_count,
	output logic [1:0]       status,
	output logic             last_word
);

	logic [255:0]       v_q, c_q, t_q;
	logic [31:0]        cnt_q, limit_q;
	logic               inst_q;
	logic [FILL_W-1:0]  fill_q;
	logic [LEN_W-1:0]   len_q, off_q;
	logic [7:0]         seed_mem [SEED_BYTES_MAX];
	logic [7:0]         rdata_q;
	logic [SEED_AW-1:0] mem_addr;
	logic               hash_busy, hash_done;
	logic [255:0]       digest;
	logic               out_valid_q;

	sm3d_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.start),
		.prefix   (cmd.prefix),
		.use_seed (cmd.use_seed),
		.inc_v    (cmd.inc_v),
		.nseed    (fill_q),
		.vec      (cmd.vsel_t ? t_q : v_q),
		.mem_addr (mem_addr),
		.mem_rdata(rdata_q),
		.busy     (hash_busy),
		.done     (hash_done),
		.digest   (digest)
	);

	// seed gather memory
	always_ff @(posedge clk) begin
		if (cmd.store_byte && (fill_q < FILL_W'(SEED_BYTES_MAX)))
			seed_mem[fill_q[SEED_AW-1:0]] <= data_byte;
		rdata_q <= seed_mem[mem_addr];
	end

	// control-like state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			inst_q  <= 1'b0;
			cnt_q   <= '0;
			limit_q <= RESEED_LIMIT_RST;
			len_q   <= '0;
			off_q   <= '0;
		end else begin
			if (cfg_we) limit_q <= cfg_wdata;
			if (cmd.fill_clr)
				fill_q <= '0;
			else if (cmd.store_byte && (fill_q < FILL_W'(SEED_BYTES_MAX)))
				fill_q <= fill_q + FILL_W'(1);
			if (cmd.inst_set) inst_q <= 1'b1;
			if (cmd.cnt_set1)
				cnt_q <= 32'd1;
			else if (cmd.cnt_inc && (cnt_q != 32'hFFFF_FFFF))
				cnt_q <= cnt_q + 32'd1;
			if (cmd.cap_len) begin
				len_q <= (request_length > REQ_MAX) ? REQ_MAX : request_length;
				off_q <= '0;
			end else if (cmd.push_data) begin
				off_q <= off_q + LEN_W'(8);
			end
		end
	end

	// V, C and the generate working value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
			c_q <= '0;
		end else begin
			if (cmd.v_load)       v_q <= digest;
			else if (cmd.v_add_h) v_q <= v_q + digest;
			else if (cmd.v_add_c) v_q <= v_q + c_q;
			else if (cmd.v_add_n) v_q <= v_q + {224'd0, cnt_q};
			if (cmd.c_load) c_q <= digest;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.t_load_v)   t_q <= v_q;
		else if (cmd.t_inc) t_q <= t_q + 256'd1;
	end

	// word selection from the current digest
	logic [255:0]     dig_sh;
	logic [LEN_W-1:0] rem;
	logic [3:0]       emit_cnt;
	logic [63:0]      mask;

	assign dig_sh   = digest >> {~off_q[4:3], 6'b000000};
	assign rem      = len_q - off_q;
	assign emit_cnt = (rem >= LEN_W'(8)) ? 4'd8 : rem[3:0];
	assign mask     = ~(64'hFFFF_FFFF_FFFF_FFFF >> {emit_cnt, 3'b000});

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push_data || cmd.push_resp) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push_data) begin
			data_word  <= dig_sh[63:0] & mask;
			byte_count <= emit_cnt;
			status     <= STS_OK;
			last_word  <= (rem <= LEN_W'(8));
		end else if (cmd.push_resp) begin
			data_word  <= '0;
			byte_count <= '0;
			status     <= cmd.rsp_status;
			last_word  <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;

	assign sts.hash_busy    = hash_busy;
	assign sts.hash_done    = hash_done;
	assign sts.inst         = inst_q;
	assign sts.reseed_req   = (cnt_q > limit_q);
	assign sts.out_free     = !out_valid_q || out_ready;
	assign sts.len_zero     = (len_q == '0);
	assign sts.emit_last    = (rem <= LEN_W'(8));
	assign sts.emit_blk_end = &off_q[4:3];

endmodule

@@ hdl/sm3d_ctrl.sv @@
// drbg controller: sequences derivations, generate blocks and state update
// depends on sm3d_pkg and sm3_hash_drbg_top_defines.svh
`include "sm3_hash_drbg_top_defines.svh"
module sm3d_ctrl import sm3d_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] in_command,
	input  logic       in_end,
	output dp_cmd_t    cmd,
	input  dp_sts_t    sts
);

	typedef enum logic [10:0] {
		S_IDLE  = 11'b000_0000_0001,
		S_HSEED = 11'b000_0000_0010,
		S_HDERC = 11'b000_0000_0100,
		S_GSEL  = 11'b000_0000_1000,
		S_GHASH = 11'b000_0001_0000,
		S_GEMIT = 11'b000_0010_0000,
		S_UHASH = 11'b000_0100_0000,
		S_ADDH  = 11'b000_1000_0000,
		S_ADDC  = 11'b001_0000_0000,
		S_ADDN  = 11'b010_0000_0000,
		S_RESP  = 11'b100_0000_0000
	} state_t;

	state_t     state_q, state_d;
	logic       reseed_q, reseed_d;
	logic [1:0] rsp_q, rsp_d;
	logic       accept;
	logic       seed_end;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign seed_end = accept && in_end && (in_command == CMD_SEED);

	// next state and datapath commands
	always_comb begin
		state_d  = state_q;
		reseed_d = reseed_q;
		rsp_d    = rsp_q;
		cmd      = '0;
		cmd.rsp_status = rsp_q;

		// message descriptor follows the hash in progress
		unique case (state_q) inside
			S_HSEED: begin
				cmd.prefix   = reseed_q ? PFX_RESEED : PFX_DERIVE;
				cmd.use_seed = 1'b1;
				cmd.inc_v    = reseed_q;
			end
			S_HDERC, S_UHASH: begin
				cmd.prefix = (state_q == S_UHASH) ? PFX_UPDATE : PFX_DERIVE;
				cmd.inc_v  = 1'b1;
			end
			S_GHASH, S_GEMIT: begin
				cmd.prefix = PFX_GEN;
				cmd.inc_v  = 1'b1;
				cmd.vsel_t = 1'b1;
			end
			default: cmd.prefix = PFX_DERIVE;
		endcase

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (in_command) inside
						CMD_SEED, CMD_RESEED: begin
							cmd.store_byte = 1'b1;
							if (in_end) begin
								if (in_command == CMD_SEED) begin
									reseed_d  = 1'b0;
									cmd.start = 1'b1;
									state_d   = S_HSEED;
								end else if (sts.inst) begin
									reseed_d  = 1'b1;
									cmd.start = 1'b1;
									state_d   = S_HSEED;
								end else begin
									cmd.fill_clr = 1'b1;
									rsp_d        = STS_NOT_INST;
									state_d      = S_RESP;
								end
							end
						end
						CMD_GEN: begin
							if (!sts.inst) begin
								rsp_d   = STS_NOT_INST;
								state_d = S_RESP;
							end else if (sts.reseed_req) begin
								rsp_d   = STS_RESEED_REQ;
								state_d = S_RESP;
							end else begin
								cmd.cap_len  = 1'b1;
								cmd.t_load_v = 1'b1;
								state_d      = S_GSEL;
							end
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_HSEED: begin
				if (sts.hash_done) begin
					cmd.v_load = 1'b1;
					cmd.start  = 1'b1;
					state_d    = S_HDERC;
				end
			end
			S_HDERC: begin
				if (sts.hash_done) begin
					cmd.c_load   = 1'b1;
					cmd.cnt_set1 = 1'b1;
					cmd.inst_set = 1'b1;
					cmd.fill_clr = 1'b1;
					rsp_d        = STS_OK;
					state_d      = S_RESP;
				end
			end
			S_GSEL: begin
				cmd.start = 1'b1;
				state_d   = sts.len_zero ? S_UHASH : S_GHASH;
			end
			S_GHASH: begin
				if (sts.hash_done) state_d = S_GEMIT;
			end
			S_GEMIT: begin
				if (sts.out_free) begin
					cmd.push_data = 1'b1;
					if (sts.emit_last) begin
						cmd.start = 1'b1;
						state_d   = S_UHASH;
					end else if (sts.emit_blk_end) begin
						cmd.t_inc = 1'b1;
						cmd.start = 1'b1;
						state_d   = S_GHASH;
					end
				end
			end
			S_UHASH: begin
				if (sts.hash_done) state_d = S_ADDH;
			end
			S_ADDH: begin
				cmd.v_add_h = 1'b1;
				state_d     = S_ADDC;
			end
			S_ADDC: begin
				cmd.v_add_c = 1'b1;
				state_d     = S_ADDN;
			end
			S_ADDN: begin
				cmd.v_add_n = 1'b1;
				cmd.cnt_inc = 1'b1;
				rsp_d       = STS_OK;
				state_d     = sts.len_zero ? S_RESP : S_IDLE;
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.push_resp = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			reseed_q <= 1'b0;
			rsp_q    <= STS_OK;
		end else begin
			state_q  <= state_d;
			reseed_q <= reseed_d;
			rsp_q    <= rsp_d;
		end
	end

	// checks
	`SM3D_ASSERT(a_push_when_free, (cmd.push_data || cmd.push_resp) |-> sts.out_free, "push while full")
	`SM3D_ASSERT(a_start_when_idle, cmd.start |-> !sts.hash_busy, "hash started while busy")
	`SM3D_ASSERT_NEXT(a_seed_end_busy, seed_end, !in_ready, "seed end did not start derivation")

endmodule

@@ hdl/sm3_hash_drbg_top.sv @@
// sm3 hash drbg top level: joins controller and datapath to the channels
// depends on sm3d_pkg, sm3d_in_if, sm3d_out_if, sm3d_ctrl, sm3d_dpath
//
// request beats carry command, data_byte, end_of_seed and request_length.
// seed and entropy bytes without the end mark are taken one per cycle and
// give no result. an end-marked beat runs the derivation or is refused, and
// gives one status beat; a generate gives a beat per 8 output bytes with
// last_word on the final one, or one status beat if refused or zero length.
// each sm3 compression streams the 64-byte padded block in, then runs 64
// rounds, one per cycle.
// a seed of n bytes costs ((n+9)/64+1) + 1 compressions, a reseed
// ((n+41)/64+1) + 1, a generate of L bytes ceil(L/32) + 1 compressions
// plus the S_GSEL start and the S_ADDH, S_ADDC, S_ADDN update states; the
// word beats of a block go out while no compression runs, so a stalled
// receiver holds the block there.
// only one request is in flight: request.ready is high while idle. results
// sit in a one-beat output register that holds while stalled. reset clears
// V, C, the counter and the instantiated flag; reseed_limit returns to 1024
// and the user writes it via cfg_we/cfg_wdata only while idle, not enforced.
module sm3_hash_drbg_top import sm3d_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	sm3d_in_if.sink     request,
	sm3d_out_if.source  result,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);

	dp_cmd_t dp_cmd;
	dp_sts_t dp_sts;

	sm3d_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (request.valid),
		.in_ready  (request.ready),
		.in_command(request.command),
		.in_end    (request.end_of_seed),
		.cmd       (dp_cmd),
		.sts       (dp_sts)
	);

	sm3d_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (dp_cmd),
		.sts           (dp_sts),
		.data_byte     (request.data_byte),
		.request_length(request.request_length),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.out_valid     (result.valid),
		.out_ready     (result.ready),
		.data_word     (result.data_word),
		.byte_count    (result.byte_count),
		.status        (result.status),
		.last_word     (result.last_word)
	);

endmodule
